[rtl/dlt_pkg.sv]
package dlt_pkg;

    // Lease phase, as reported on phase_now.
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_BOUND     = 3'd1,
        PH_RENEWING  = 3'd2,
        PH_REBINDING = 3'd3,
        PH_EXPIRED   = 3'd4
    } phase_t;

    // Action requested from the client.
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_RENEW  = 2'd1,
        ACT_REBIND = 2'd2
    } action_t;

    // Item kinds.
    localparam logic KIND_POLL = 1'b0;
    localparam logic KIND_BIND = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_RENEW_DELAY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REBIND_DELAY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRE_DELAY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_DELAY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPT_LIMIT = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [31:0] RETRY_DELAY_RESET   = 32'd2000;
    localparam logic [7:0]  ATTEMPT_LIMIT_RESET = 8'd4;

    // Address values that a bind may not carry.
    localparam logic [31:0] ADDR_NONE  = 32'h0000_0000;
    localparam logic [31:0] ADDR_BCAST = 32'hFFFF_FFFF;

    // Time plus a delay, held at the largest time instead of wrapping.
    function automatic logic [63:0] sat_add(input logic [63:0] t, input logic [31:0] d);
        logic [64:0] sum;
        sum = {1'b0, t} + {33'd0, d};
        return sum[64] ? {64{1'b1}} : sum[63:0];
    endfunction

endpackage

[rtl/dhcp_lease_timer_unit.sv]
// Channel | Direction | Handshake           | Payload
// --------+-----------+---------------------+--------------------------------------
// cfg     | in        | cfg_write_en        | cfg_index, cfg_data
// in      | in        | in_valid / in_ready | kind, now_ms, lease_address
// out     | out       | out_valid/out_ready | action, bind_rejected, phase_now
//
// Every input beat gives exactly one output beat: it is captured in the input register
// and then registered in the result register. One beat is taken per cycle while the output
// is not stalled: the input register and the result register form a two-stage pipeline, and
// the lease state is updated as a beat moves into the result.
// The longest path is a 64-bit deadline compare feeding the phase and send selection;
// the saturating adds run beside it.
// Reset clears the phase, deadlines and attempt count and returns the configuration to
// its reset values at once.
// A stall on the output holds a beat in each full stage; in_ready drops only when both
// stages are full and out_ready is low.
module dhcp_lease_timer_unit
    import dlt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 kind,
    input  logic [63:0]          now_ms,
    input  logic [31:0]          lease_address,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           action,
    output logic                 bind_rejected,
    output logic [2:0]           phase_now
);

    // Configuration registers.
    logic [31:0] renew_delay_reg;
    logic [31:0] rebind_delay_reg;
    logic [31:0] expire_delay_reg;
    logic [31:0] retry_delay_reg;
    logic [7:0]  attempt_limit_reg;

    // Lease state.
    phase_t      phase_reg,   phase_next;
    logic [63:0] renew_at_reg,    renew_at_next;
    logic [63:0] rebind_at_reg,   rebind_at_next;
    logic [63:0] expire_at_reg,   expire_at_next;
    logic [63:0] next_try_at_reg, next_try_at_next;
    logic [7:0]  tries_reg,   tries_next;

    // Input stage.
    logic        in_valid_reg;
    logic        kind_reg;
    logic [63:0] now_reg;
    logic [31:0] addr_reg;

    // Result stage.
    logic        out_valid_reg;
    action_t     out_action_reg,   out_action_next;
    logic        out_rejected_reg, out_rejected_next;
    phase_t      out_phase_reg;

    logic advance;

    // The input stage moves on whenever the result register is free or being taken.
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            renew_delay_reg   <= '0;
            rebind_delay_reg  <= '0;
            expire_delay_reg  <= '0;
            retry_delay_reg   <= RETRY_DELAY_RESET;
            attempt_limit_reg <= ATTEMPT_LIMIT_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_RENEW_DELAY:   renew_delay_reg   <= cfg_data;
                CFG_REBIND_DELAY:  rebind_delay_reg  <= cfg_data;
                CFG_EXPIRE_DELAY:  expire_delay_reg  <= cfg_data;
                CFG_RETRY_DELAY:   retry_delay_reg   <= cfg_data;
                CFG_ATTEMPT_LIMIT: attempt_limit_reg <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg <= kind;
            now_reg  <= now_ms;
            addr_reg <= lease_address;
        end
    end

    // Bind check, deadline tracking and retry logic for the beat in the input stage.
    always_comb
    begin
        logic   bind_ok;
        logic   active;
        logic   entered;
        logic   send;
        phase_t ph2;
        logic [7:0]  t2;
        logic [63:0] nt2;

        phase_next        = phase_reg;
        renew_at_next     = renew_at_reg;
        rebind_at_next    = rebind_at_reg;
        expire_at_next    = expire_at_reg;
        next_try_at_next  = next_try_at_reg;
        tries_next        = tries_reg;
        out_action_next   = ACT_NONE;
        out_rejected_next = 1'b0;

        bind_ok = (addr_reg != ADDR_NONE) && (addr_reg != ADDR_BCAST) &&
                  (renew_delay_reg != 32'd0) &&
                  (renew_delay_reg < rebind_delay_reg) &&
                  (rebind_delay_reg < expire_delay_reg);
        active  = (phase_reg == PH_BOUND) || (phase_reg == PH_RENEWING) ||
                  (phase_reg == PH_REBINDING);

        // Phase entry on a poll.
        entered = 1'b0;
        ph2     = phase_reg;
        t2      = tries_reg;
        nt2     = next_try_at_reg;
        if (now_reg >= rebind_at_reg && phase_reg != PH_REBINDING)
        begin
            entered = 1'b1;
            ph2     = PH_REBINDING;
            t2      = 8'd0;
            nt2     = now_reg;
        end
        else if (now_reg >= renew_at_reg && phase_reg == PH_BOUND)
        begin
            entered = 1'b1;
            ph2     = PH_RENEWING;
            t2      = 8'd0;
            nt2     = now_reg;
        end
        send = (ph2 != PH_BOUND) && (t2 < attempt_limit_reg) &&
               (entered || now_reg >= next_try_at_reg);

        if (kind_reg == KIND_BIND)
        begin
            if (bind_ok)
            begin
                phase_next       = PH_BOUND;
                renew_at_next    = sat_add(now_reg, renew_delay_reg);
                rebind_at_next   = sat_add(now_reg, rebind_delay_reg);
                expire_at_next   = sat_add(now_reg, expire_delay_reg);
                next_try_at_next = sat_add(now_reg, renew_delay_reg);
                tries_next       = 8'd0;
            end
            else
            begin
                out_rejected_next = 1'b1;
            end
        end
        else if (active)
        begin
            if (now_reg >= expire_at_reg)
            begin
                phase_next = PH_EXPIRED;
                tries_next = 8'd0;
            end
            else
            begin
                phase_next = ph2;
                if (send)
                begin
                    tries_next       = t2 + 8'd1;
                    next_try_at_next = sat_add(now_reg, retry_delay_reg);
                    out_action_next  = (ph2 == PH_RENEWING) ? ACT_RENEW : ACT_REBIND;
                end
                else
                begin
                    tries_next       = t2;
                    next_try_at_next = nt2;
                end
            end
        end
    end

    // Lease state, updated as a beat moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            renew_at_reg    <= '0;
            rebind_at_reg   <= '0;
            expire_at_reg   <= '0;
            next_try_at_reg <= '0;
            tries_reg       <= '0;
        end
        else if (in_valid_reg && advance)
        begin
            phase_reg       <= phase_next;
            renew_at_reg    <= renew_at_next;
            rebind_at_reg   <= rebind_at_next;
            expire_at_reg   <= expire_at_next;
            next_try_at_reg <= next_try_at_next;
            tries_reg       <= tries_next;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid_reg && advance)
        begin
            out_action_reg   <= out_action_next;
            out_rejected_reg <= out_rejected_next;
            out_phase_reg    <= phase_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign action        = out_action_reg;
    assign bind_rejected = out_rejected_reg;
    assign phase_now     = out_phase_reg;

    // A rejected bind never asks for a send.
    a_reject_no_action: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_rejected_reg |-> out_action_reg == ACT_NONE)
        else $error("rejected bind carries an action");

    // A send is only requested while renewing or rebinding.
    a_action_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_action_reg != ACT_NONE |->
            out_phase_reg == PH_RENEWING || out_phase_reg == PH_REBINDING)
        else $error("send requested outside renewing or rebinding");

    // Once a lease has been bound the phase never returns to idle.
    a_no_return_idle: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_IDLE |=> phase_reg != PH_IDLE)
        else $error("phase returned to idle");

    // A beat held in the input stage keeps its payload while the output stalls.
    a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=>
            in_valid_reg && $stable(now_reg) && $stable(kind_reg) && $stable(addr_reg))
        else $error("input stage lost a stalled beat");

    // A beat leaving the input stage always lands in the result register.
    a_beat_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && advance |=> out_valid_reg)
        else $error("beat dropped between stages");

endmodule

[tb/sv/tb_top.sv]
module tb_top;
    import dlt_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BEATS = 1250;
    localparam int DRAIN_CYCLES = 4;
    localparam int REPORT_MAX   = 10;

    // One result beat as the block reports it.
    typedef struct packed {
        action_t act;
        logic    rej;
        phase_t  ph;
    } lease_result_t;

    typedef enum logic {ROW_BEAT, ROW_REG} row_op_t;

    // One row of the directed table: an input beat or a register write.
    typedef struct {
        row_op_t              op;
        logic                 k;
        logic [63:0]          stamp;
        logic [31:0]          word;
        logic [CFG_IDX_W-1:0] idx;
        logic                 fixed;
        lease_result_t        want;
    } stim_row_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_write_en  = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [31:0]          cfg_data      = '0;
    logic                 in_valid      = 1'b0;
    logic                 in_ready;
    logic                 kind          = 1'b0;
    logic [63:0]          now_ms        = '0;
    logic [31:0]          lease_address = '0;
    logic                 out_valid;
    logic                 out_ready     = 1'b0;
    logic [1:0]           action;
    logic                 bind_rejected;
    logic [2:0]           phase_now;

    // Settings as the block holds them.
    logic [31:0] set_renew  = 32'd0;
    logic [31:0] set_rebind = 32'd0;
    logic [31:0] set_expire = 32'd0;
    logic [31:0] set_retry  = RETRY_DELAY_RESET;
    logic [7:0]  set_limit  = ATTEMPT_LIMIT_RESET;

    // Lease state as the block should hold it.
    phase_t      lease_ph   = PH_IDLE;
    logic [31:0] lease_addr = '0;
    logic [63:0] renew_at   = '0;
    logic [63:0] rebind_at  = '0;
    logic [63:0] expire_at  = '0;
    logic [63:0] retry_at   = '0;
    logic [7:0]  sent_count = '0;

    lease_result_t pending_results[$];
    stim_row_t     stim_rows[$];
    int            mismatches   = 0;
    int            results_seen = 0;
    int            beats_sent   = 0;
    int            cycle_count  = 0;
    logic          calm         = 1'b0;

    dhcp_lease_timer_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .now_ms        (now_ms),
        .lease_address (lease_address),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .action        (action),
        .bind_rejected (bind_rejected),
        .phase_now     (phase_now)
    );

    always #5 clk = ~clk;

    // Hard stop in case a handshake never completes.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Time plus delay, clamped at the largest time.
    function automatic logic [63:0] add_clamped(input logic [63:0] t, input logic [31:0] d);
        logic [63:0] room;
        room = ~t;
        return (room < {32'd0, d}) ? {64{1'b1}} : t + {32'd0, d};
    endfunction

    function automatic void note_register(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [31:0] val);
        case (idx)
            CFG_RENEW_DELAY:   set_renew  = val;
            CFG_REBIND_DELAY:  set_rebind = val;
            CFG_EXPIRE_DELAY:  set_expire = val;
            CFG_RETRY_DELAY:   set_retry  = val;
            CFG_ATTEMPT_LIMIT: set_limit  = val[7:0];
            default: ;
        endcase
    endfunction

    // Advances the lease state by one beat and returns the result it should give.
    function automatic lease_result_t lease_step(input logic k, input logic [63:0] t,
                                                 input logic [31:0] a);
        lease_result_t res;
        res.act = ACT_NONE;
        res.rej = 1'b0;
        if (k == KIND_BIND)
        begin
            if (a == ADDR_NONE || a == ADDR_BCAST || set_renew == 32'd0 ||
                set_renew >= set_rebind || set_rebind >= set_expire)
            begin
                res.rej = 1'b1;
            end
            else
            begin
                lease_ph   = PH_BOUND;
                lease_addr = a;
                renew_at   = add_clamped(t, set_renew);
                rebind_at  = add_clamped(t, set_rebind);
                expire_at  = add_clamped(t, set_expire);
                retry_at   = renew_at;
                sent_count = '0;
            end
        end
        else if (lease_ph == PH_BOUND || lease_ph == PH_RENEWING || lease_ph == PH_REBINDING)
        begin
            if (t >= expire_at)
            begin
                lease_ph   = PH_EXPIRED;
                sent_count = '0;
            end
            else
            begin
                // Phase entry: rebinding takes priority over renewing.
                if (t >= rebind_at && lease_ph != PH_REBINDING)
                begin
                    lease_ph   = PH_REBINDING;
                    sent_count = '0;
                    retry_at   = t;
                end
                else if (t >= renew_at && lease_ph == PH_BOUND)
                begin
                    lease_ph   = PH_RENEWING;
                    sent_count = '0;
                    retry_at   = t;
                end
                if (lease_ph != PH_BOUND && sent_count < set_limit && t >= retry_at)
                begin
                    sent_count = sent_count + 8'd1;
                    retry_at   = add_clamped(t, set_retry);
                    res.act    = (lease_ph == PH_RENEWING) ? ACT_RENEW : ACT_REBIND;
                end
            end
        end
        res.ph = lease_ph;
        return res;
    endfunction

    function automatic void dir_beat(input logic k, input logic [63:0] t, input logic [31:0] a);
        stim_rows.push_back('{ROW_BEAT, k, t, a, '0, 1'b0, '0});
    endfunction

    function automatic void dir_fixed(input logic k, input logic [63:0] t,
                                      input logic [31:0] a, input lease_result_t want);
        stim_rows.push_back('{ROW_BEAT, k, t, a, '0, 1'b1, want});
    endfunction

    function automatic void dir_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        stim_rows.push_back('{ROW_REG, 1'b0, 64'd0, val, idx, 1'b0, '0});
    endfunction

    function automatic logic [31:0] draw_address();
        if ($urandom_range(0, 19) == 0)
            return ($urandom_range(0, 1) == 0) ? ADDR_NONE : ADDR_BCAST;
        return $urandom;
    endfunction

    // Register write; the caller lowers the enable after its last write.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        note_register(idx, val);
    endtask

    task automatic load_settings(input logic [31:0] rn, input logic [31:0] rb,
                                 input logic [31:0] ex, input logic [31:0] rt,
                                 input logic [31:0] lim);
        write_register(CFG_RENEW_DELAY, rn);
        write_register(CFG_REBIND_DELAY, rb);
        write_register(CFG_EXPIRE_DELAY, ex);
        write_register(CFG_RETRY_DELAY, rt);
        write_register(CFG_ATTEMPT_LIMIT, lim);
        cfg_write_en <= 1'b0;
    endtask

    // Stops sending and waits until every result is back and the pipeline is empty.
    task automatic wait_idle();
        in_valid     <= 1'b0;
        cfg_write_en <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Presents one input beat after a random gap and records its expected result.
    task automatic send_beat(input logic k, input logic [63:0] t, input logic [31:0] a,
                             input logic fixed, input lease_result_t want);
        int            gap;
        logic          took;
        lease_result_t got;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= k;
        now_ms        <= t;
        lease_address <= a;
        do
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
        while (!took);
        got = lease_step(k, t, a);
        pending_results.push_back(fixed ? want : got);
        beats_sent++;
    endtask

    // Result side: random stalls, and each beat compared with the oldest expectation.
    initial
    begin : result_side
        int            stall;
        logic          took;
        lease_result_t want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
            begin
                @(negedge clk);
                took = out_valid;
                if (took)
                begin
                    if (pending_results.size() == 0)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("unexpected result: action %0d rejected %0b phase %0d",
                                     action, bind_rejected, phase_now);
                    end
                    else
                    begin
                        want = pending_results.pop_front();
                        if (action !== want.act || bind_rejected !== want.rej ||
                            phase_now !== want.ph)
                        begin
                            mismatches++;
                            if (mismatches <= REPORT_MAX)
                                $display({"result %0d: expected action %0d rejected %0b ",
                                          "phase %0d, got action %0d rejected %0b phase %0d"},
                                         results_seen, want.act, want.rej, want.ph,
                                         action, bind_rejected, phase_now);
                        end
                    end
                    results_seen++;
                end
                @(posedge clk);
            end
            while (!took);
        end
    end

    initial
    begin : stimulus
        int          n;
        int          r;
        int          m;
        int          first_random;
        bit          in_cfg;
        logic [63:0] clock_ms;
        logic [31:0] scale;
        logic [31:0] step;
        logic [31:0] rn;
        logic [31:0] rb;
        logic [31:0] ex;
        logic [31:0] rt;
        logic [31:0] lim;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: polls do nothing while idle, and a zero renew delay refuses binds.
        dir_fixed(KIND_POLL, 64'd0, 32'h0A00_0001, '{ACT_NONE, 1'b0, PH_IDLE});
        dir_fixed(KIND_BIND, 64'd100, 32'h0A00_0001, '{ACT_NONE, 1'b1, PH_IDLE});

        // A short lease with two attempts per phase and a 300 ms retry gap.
        dir_reg(CFG_RENEW_DELAY, 32'd1000);
        dir_reg(CFG_REBIND_DELAY, 32'd2000);
        dir_reg(CFG_EXPIRE_DELAY, 32'd3000);
        dir_reg(CFG_RETRY_DELAY, 32'd300);
        dir_reg(CFG_ATTEMPT_LIMIT, 32'd2);
        dir_fixed(KIND_BIND, 64'd0, ADDR_NONE, '{ACT_NONE, 1'b1, PH_IDLE});
        dir_fixed(KIND_BIND, 64'd0, ADDR_BCAST, '{ACT_NONE, 1'b1, PH_IDLE});
        dir_beat(KIND_BIND, 64'd0, 32'hC0A8_0001);
        dir_beat(KIND_POLL, 64'd999, 32'd0);
        dir_beat(KIND_POLL, 64'd1000, 32'd0);
        dir_beat(KIND_POLL, 64'd1100, 32'd0);
        dir_beat(KIND_POLL, 64'd1300, 32'd0);
        dir_beat(KIND_POLL, 64'd1700, 32'd0);
        dir_beat(KIND_POLL, 64'd2000, 32'd0);
        // Time stepping backwards while rebinding.
        dir_beat(KIND_POLL, 64'd500, 32'd0);
        dir_beat(KIND_POLL, 64'd3000, 32'd0);
        dir_beat(KIND_POLL, 64'd5000, 32'd0);

        // Bind close to the end of time so that the later deadlines clamp.
        dir_beat(KIND_BIND, 64'hFFFF_FFFF_FFFF_FFFF - 64'd1500, 32'h8000_0000);
        dir_beat(KIND_POLL, 64'hFFFF_FFFF_FFFF_FFFF - 64'd500, 32'd0);
        dir_beat(KIND_POLL, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);

        // Badly ordered delays and a zero renew delay are all refused.
        dir_reg(CFG_REBIND_DELAY, 32'd1000);
        dir_beat(KIND_BIND, 64'd10, 32'h0A00_0002);
        dir_reg(CFG_REBIND_DELAY, 32'd2000);
        dir_reg(CFG_EXPIRE_DELAY, 32'd2000);
        dir_beat(KIND_BIND, 64'd10, 32'h0A00_0002);
        dir_reg(CFG_RENEW_DELAY, 32'd0);
        dir_reg(CFG_EXPIRE_DELAY, 32'd3000);
        dir_beat(KIND_BIND, 64'd10, 32'h0A00_0002);

        // Widest legal delays, longest retry gap, largest attempt limit.
        dir_reg(CFG_RENEW_DELAY, 32'd1);
        dir_reg(CFG_REBIND_DELAY, 32'hFFFF_FFFE);
        dir_reg(CFG_EXPIRE_DELAY, 32'hFFFF_FFFF);
        dir_reg(CFG_RETRY_DELAY, 32'hFFFF_FFFF);
        dir_reg(CFG_ATTEMPT_LIMIT, 32'd255);
        dir_beat(KIND_BIND, 64'd0, 32'h0000_0001);
        dir_beat(KIND_POLL, 64'd1, 32'd0);
        dir_beat(KIND_POLL, 64'd2, 32'd0);

        // An attempt limit of zero never sends anything.
        dir_reg(CFG_RENEW_DELAY, 32'd10);
        dir_reg(CFG_REBIND_DELAY, 32'd20);
        dir_reg(CFG_EXPIRE_DELAY, 32'd30);
        dir_reg(CFG_RETRY_DELAY, 32'd0);
        dir_reg(CFG_ATTEMPT_LIMIT, 32'd0);
        dir_beat(KIND_BIND, 64'd0, 32'h7FFF_FFFF);
        dir_beat(KIND_POLL, 64'd15, 32'd0);
        dir_beat(KIND_POLL, 64'd25, 32'd0);

        // Walk the table; a group of writes starts only once the block is idle.
        in_cfg = 1'b0;
        foreach (stim_rows[i])
        begin
            if (stim_rows[i].op == ROW_REG)
            begin
                if (!in_cfg)
                    wait_idle();
                write_register(stim_rows[i].idx, stim_rows[i].word);
                in_cfg = 1'b1;
            end
            else
            begin
                if (in_cfg)
                    cfg_write_en <= 1'b0;
                in_cfg = 1'b0;
                send_beat(stim_rows[i].k, stim_rows[i].stamp, stim_rows[i].word,
                          stim_rows[i].fixed, stim_rows[i].want);
            end
        end

        // Random leases: new settings, a bind, then mostly forward-moving polls.
        first_random = beats_sent;
        while (beats_sent - first_random < RANDOM_BEATS)
        begin
            wait_idle();
            calm = ($urandom_range(0, 4) == 0);
            m = $urandom_range(0, 9);
            if (m <= 5)
            begin
                rn  = $urandom_range(1, 1000);
                rb  = rn + $urandom_range(1, 1000);
                ex  = rb + $urandom_range(1, 1000);
                rt  = $urandom_range(0, 400);
                lim = $urandom_range(0, 6);
            end
            else if (m <= 7)
            begin
                rn  = $urandom_range(1, 32'h4000_0000);
                rb  = rn + $urandom_range(1, 32'h4000_0000);
                ex  = rb + $urandom_range(1, 32'h4000_0000);
                rt  = $urandom;
                lim = $urandom_range(0, 255);
            end
            else if (m == 8)
            begin
                rn  = $urandom;
                rb  = $urandom;
                ex  = $urandom;
                rt  = $urandom;
                lim = $urandom;
            end
            else
            begin
                rn  = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'd1;
                rb  = 32'hFFFF_FFFE;
                ex  = 32'hFFFF_FFFF;
                rt  = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
                lim = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'd255;
            end
            load_settings(rn, rb, ex, rt, lim);
            scale = ex / 12 + 32'd1;

            r = $urandom_range(0, 9);
            if (r == 0)
                clock_ms = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 5000);
            else if (r == 1)
                clock_ms = {32'd0, $urandom_range(0, 10000)};
            else
                clock_ms = {$urandom, $urandom};
            send_beat(KIND_BIND, clock_ms, draw_address(), 1'b0, '0);

            n = $urandom_range(10, 60);
            repeat (n)
            begin
                r = $urandom_range(0, 19);
                if (r == 0)
                begin
                    send_beat(1'($urandom_range(0, 1)), {$urandom, $urandom}, $urandom,
                              1'b0, '0);
                end
                else if (r == 1)
                begin
                    send_beat(KIND_BIND, clock_ms, draw_address(), 1'b0, '0);
                end
                else
                begin
                    if (r == 2)
                    begin
                        step = $urandom_range(0, scale);
                        clock_ms = (clock_ms < {32'd0, step}) ? 64'd0 :
                                   clock_ms - {32'd0, step};
                    end
                    else
                    begin
                        clock_ms = add_clamped(clock_ms, $urandom_range(0, 2 * scale));
                    end
                    send_beat(KIND_POLL, clock_ms, $urandom, 1'b0, '0);
                end
            end
        end

        wait_idle();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
